// ===== design/wmd_pkg.sv =====
`timescale 1ns / 1ps

package wmd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int COL_W      = 16;
  localparam int FRAME_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 32;
  localparam int BOUND_W    = FRAME_W + FRAC_W;
  localparam int NUMCH_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS = 3'd0,
    REG_STEP         = 3'd1,
    REG_START_INDEX  = 3'd2,
    REG_START_FRAC   = 3'd3,
    REG_END_INDEX    = 3'd4,
    REG_COLUMN_LIMIT = 3'd5
  } cfg_reg_e;

  // hand-off from the accumulator to the output buffer
  typedef struct packed {
    logic             load;
    logic [COL_W-1:0] column_index;
  } snap_ctrl_t;

endpackage

// ===== design/wmd_accum.sv =====
`timescale 1ns / 1ps

module wmd_accum #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    restart,
  input  logic [wmd_pkg::NUMCH_W-1:0]             num_channels,
  input  logic [wmd_pkg::STEP_W-1:0]              step,
  input  logic [wmd_pkg::FRAME_W-1:0]             start_index,
  input  logic [wmd_pkg::FRAC_W-1:0]              start_frac,
  input  logic [wmd_pkg::FRAME_W-1:0]             end_index,
  input  logic [wmd_pkg::COL_W-1:0]               column_limit,
  input  logic                                    s1_valid,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0]     s1_high,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0]     s1_low,
  input  logic [wmd_pkg::CHAN_W-1:0]              s1_channel,
  input  logic                                    buf_free,
  output logic                                    stall,
  output logic [$clog2(MAX_CHANNELS+1) > 3 ? $clog2(MAX_CHANNELS+1)-1 : 2:0] nc,
  output wmd_pkg::snap_ctrl_t                     snap_ctrl,
  output logic signed [wmd_pkg::SAMPLE_W-1:0]     snap_max [MAX_CHANNELS],
  output logic signed [wmd_pkg::SAMPLE_W-1:0]     snap_min [MAX_CHANNELS]
);
  import wmd_pkg::*;

  localparam int CMP_W = ($clog2(MAX_CHANNELS + 1) > 3) ? $clog2(MAX_CHANNELS + 1) : 3;
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [FRAME_W-1:0]         frame_index;
  logic [BOUND_W-1:0]         boundary;
  logic [COL_W-1:0]           columns_done;
  logic                       column_open;
  logic                       finished;
  logic signed [SAMPLE_W-1:0] run_max [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] run_min [MAX_CHANNELS];

  logic [CMP_W-1:0]           nc_next;
  logic [CMP_W-1:0]           ch_cmp;
  logic [IDX_W-1:0]           idx;
  logic                       fin_now;
  logic                       in_range;
  logic                       is_last_ch;
  logic                       close_cond;
  logic                       want_close;
  logic                       fire;
  logic signed [SAMPLE_W-1:0] new_max;
  logic signed [SAMPLE_W-1:0] new_min;
  logic [COL_W-1:0]           cols_inc;
  logic [BOUND_W:0]           bound_sum;
  logic [BOUND_W:0]           start_sum;

  always_comb begin
    if (num_channels == '0) begin
      nc_next = CMP_W'(1);
    end else if (32'(num_channels) > MAX_CHANNELS) begin
      nc_next = CMP_W'(MAX_CHANNELS);
    end else begin
      nc_next = CMP_W'(num_channels);
    end
  end

  assign ch_cmp     = CMP_W'(s1_channel);
  assign idx        = ch_cmp[IDX_W-1:0];
  assign fin_now    = finished || (columns_done >= column_limit) || (frame_index > end_index);
  assign in_range   = ch_cmp < nc;
  assign is_last_ch = ch_cmp == (nc - CMP_W'(1));
  assign close_cond = ({1'b0, frame_index} + 33'd1 >= {1'b0, boundary[BOUND_W-1:FRAC_W]})
                      || (frame_index >= end_index);
  assign want_close = s1_valid && !fin_now && in_range && is_last_ch && close_cond;
  assign stall      = want_close && !buf_free;
  assign fire       = s1_valid && !stall;

  assign new_max = (!column_open || s1_high > run_max[idx]) ? s1_high : run_max[idx];
  assign new_min = (!column_open || s1_low < run_min[idx]) ? s1_low : run_min[idx];

  assign cols_inc  = columns_done + COL_W'(1);
  assign bound_sum = {1'b0, boundary} + (BOUND_W + 1)'(step);
  assign start_sum = {1'b0, start_index, start_frac} + (BOUND_W + 1)'(step);

  // the closing sample is merged into the copy handed to the output buffer
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      snap_max[c] = (IDX_W'(c) == idx) ? new_max : run_max[c];
      snap_min[c] = (IDX_W'(c) == idx) ? new_min : run_min[c];
    end
  end

  assign snap_ctrl.load         = fire && want_close;
  assign snap_ctrl.column_index = columns_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      finished    <= 1'b0;
      column_open <= 1'b0;
    end else if (restart) begin
      finished    <= 1'b0;
      column_open <= 1'b0;
    end else if (fire) begin
      if (fin_now) begin
        finished <= 1'b1;
      end else if (in_range && is_last_ch) begin
        column_open <= !close_cond;
        if (close_cond && ((frame_index >= end_index) || (cols_inc >= column_limit)
                           || (cols_inc == '0))) begin
          finished <= 1'b1;
        end
      end else if (in_range) begin
        column_open <= column_open;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      nc           <= nc_next;
      frame_index  <= start_index;
      boundary     <= start_sum[BOUND_W] ? {BOUND_W{1'b1}} : start_sum[BOUND_W-1:0];
      columns_done <= '0;
    end else if (fire && !fin_now && in_range && is_last_ch) begin
      frame_index <= frame_index + FRAME_W'(1);
      if (close_cond) begin
        columns_done <= cols_inc;
        boundary     <= bound_sum[BOUND_W] ? {BOUND_W{1'b1}} : bound_sum[BOUND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !fin_now && in_range) begin
      run_max[idx] <= new_max;
      run_min[idx] <= new_min;
    end
  end

endmodule

// ===== design/wmd_outbuf.sv =====
`timescale 1ns / 1ps

module wmd_outbuf #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wmd_pkg::snap_ctrl_t                 snap_ctrl,
  input  logic [$clog2(MAX_CHANNELS+1) > 3 ? $clog2(MAX_CHANNELS+1)-1 : 2:0] nc,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0] snap_max [MAX_CHANNELS],
  input  logic signed [wmd_pkg::SAMPLE_W-1:0] snap_min [MAX_CHANNELS],
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [wmd_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  output logic                                buf_free
);
  import wmd_pkg::*;

  localparam int CMP_W = ($clog2(MAX_CHANNELS + 1) > 3) ? $clog2(MAX_CHANNELS + 1) : 3;
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PAD_W = M_TDATA_W - 2 * SAMPLE_W - CHAN_W - COL_W;

  logic                       busy;
  logic [IDX_W-1:0]           rd;
  logic [CMP_W-1:0]           nc_out;
  logic [COL_W-1:0]           col_idx;
  logic signed [SAMPLE_W-1:0] obuf_max [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] obuf_min [MAX_CHANNELS];
  logic                       rd_last;

  assign rd_last  = CMP_W'(rd) == (nc_out - CMP_W'(1));
  assign buf_free = !busy || (m_tready && rd_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (snap_ctrl.load) begin
      busy <= 1'b1;
    end else if (busy && m_tready && rd_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ctrl.load) begin
      rd       <= '0;
      nc_out   <= nc;
      col_idx  <= snap_ctrl.column_index;
      obuf_max <= snap_max;
      obuf_min <= snap_min;
    end else if (busy && m_tready && !rd_last) begin
      rd <= rd + IDX_W'(1);
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = rd_last;
  assign m_tdata  = {PAD_W'(0), col_idx, CHAN_W'(rd), obuf_min[rd], obuf_max[rd]};

endmodule

// ===== design/waveform_minmax_decimator.sv =====
`timescale 1ns / 1ps

// min/max peak decimator for interleaved 16-bit audio
//
// input stream: one beat per sample, channel zero first in each frame;
// a beat is taken whenever s_tvalid and s_tready are high together
// output stream: when a column closes, one beat per channel (channel zero
// first) with the column max/min, m_tlast set on the final channel
// config: cfg_we writes register cfg_index (num_channels, step, start_index,
// start_frac, end_index, column_limit); every write to a mapped register
// restarts the run in the following cycle, so write only while the block is idle
//
// throughput: one sample per cycle unless stalled; a column yields one beat per
// active channel and spans at least one frame, so the output keeps pace;
// a closing sample goes from the input register stage to the output buffer and
// out as the first result beat; the rest follow one per cycle while m_tready holds
// stall: the column copy sits in an output buffer while the next column
// builds up; the input stalls only when another column is ready to close
// before the buffer has drained
// reset: registers take their reset values, output buffer is emptied and
// the run restarts through the restart strobe that reset sets
module waveform_minmax_decimator #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_high [15:0], sample_low [31:16], channel [34:32]
  input  logic [wmd_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // column_max [15:0], column_min [31:16], out_channel [34:32], column_index [50:35]
  output logic [wmd_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [wmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wmd_pkg::*;

  localparam int CMP_W = ($clog2(MAX_CHANNELS + 1) > 3) ? $clog2(MAX_CHANNELS + 1) : 3;

  // configuration registers
  logic [NUMCH_W-1:0]  num_channels;
  logic [STEP_W-1:0]   step;
  logic [FRAME_W-1:0]  start_index;
  logic [FRAC_W-1:0]   start_frac;
  logic [FRAME_W-1:0]  end_index;
  logic [COL_W-1:0]    column_limit;
  logic                restart;

  // input register stage
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_high;
  logic signed [SAMPLE_W-1:0] s1_low;
  logic [CHAN_W-1:0]          s1_channel;

  logic                       stall;
  logic                       buf_free;
  logic [CMP_W-1:0]           nc;
  snap_ctrl_t                 snap_ctrl;
  logic signed [SAMPLE_W-1:0] snap_max [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] snap_min [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= NUMCH_W'(1);
      step         <= STEP_W'(32'h0001_0000);
      start_index  <= '0;
      start_frac   <= '0;
      end_index    <= '0;
      column_limit <= COL_W'(1);
      restart      <= 1'b1;
    end else begin
      // any write to a mapped register restarts the run
      restart <= cfg_we && (cfg_index <= REG_COLUMN_LIMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_CHANNELS: begin
            num_channels <= cfg_wdata[NUMCH_W-1:0];
          end
          REG_STEP: begin
            step <= cfg_wdata[STEP_W-1:0];
          end
          REG_START_INDEX: begin
            start_index <= cfg_wdata[FRAME_W-1:0];
          end
          REG_START_FRAC: begin
            start_frac <= cfg_wdata[FRAC_W-1:0];
          end
          REG_END_INDEX: begin
            end_index <= cfg_wdata[FRAME_W-1:0];
          end
          REG_COLUMN_LIMIT: begin
            column_limit <= cfg_wdata[COL_W-1:0];
          end
          // unmapped index: ignored, no restart
          default: ;
        endcase
      end
    end
  end

  // the stage takes a new sample when empty or when its sample is consumed this cycle
  assign s_tready = !s1_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_high    <= s_tdata[SAMPLE_W-1:0];
      s1_low     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      s1_channel <= s_tdata[2*SAMPLE_W+CHAN_W-1:2*SAMPLE_W];
    end
  end

  wmd_accum #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .num_channels (num_channels),
    .step         (step),
    .start_index  (start_index),
    .start_frac   (start_frac),
    .end_index    (end_index),
    .column_limit (column_limit),
    .s1_valid     (s1_valid),
    .s1_high      (s1_high),
    .s1_low       (s1_low),
    .s1_channel   (s1_channel),
    .buf_free     (buf_free),
    .stall        (stall),
    .nc           (nc),
    .snap_ctrl    (snap_ctrl),
    .snap_max     (snap_max),
    .snap_min     (snap_min)
  );

  wmd_outbuf #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .snap_ctrl (snap_ctrl),
    .nc        (nc),
    .snap_max  (snap_max),
    .snap_min  (snap_min),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .buf_free  (buf_free)
  );

endmodule

// ===== design/wmd_checker.sv =====
`timescale 1ns / 1ps

module wmd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [wmd_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tlast
);
  import wmd_pkg::*;

  localparam int CH_LO  = 2 * SAMPLE_W;
  localparam int COL_LO = CH_LO + CHAN_W;

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a column drains without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("column drain broke off before the last beat");

  // column index is the same on every beat of one column
  a_col_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tdata[COL_LO+COL_W-1:COL_LO] == $past(m_tdata[COL_LO+COL_W-1:COL_LO]))
    else $error("column index changed within a column");

  // a new column starts at channel zero
  a_ch_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[CH_LO+CHAN_W-1:CH_LO] == '0)
    else $error("column did not start at channel zero");

endmodule

bind waveform_minmax_decimator wmd_checker u_wmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
